// File: hw/rtl/spq_pkg.sv
package spq_pkg;

	localparam int LVL_W      = 2;
	localparam int TAG_W      = 32;
	localparam int OCC_W      = 5;
	localparam int DEPTH_DEF  = 16;
	localparam int LEVELS_DEF = 3;

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [LVL_W-1:0] level;
		logic [TAG_W-1:0] name;
		logic [TAG_W-1:0] ident;
	} entry_t;

	typedef struct packed {
		logic   push;
		logic   pop;
		entry_t entry;
	} cell_ctl_t;

endpackage

// File: hw/rtl/spq_cell.sv
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctl_t ctl,
	input  logic               occupied,
	input  logic               left_ge,
	input  spq_pkg::entry_t    left_entry,
	input  spq_pkg::entry_t    right_entry,
	output spq_pkg::entry_t    entry,
	output logic               ge
);

	spq_pkg::entry_t entry_q;

	// The held entry stays in front of a new one of equal or lower level.
	assign ge    = occupied && (entry_q.level >= ctl.entry.level);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			if (!ge) begin
				if (left_ge) begin
					entry_q <= ctl.entry;
				end else begin
					entry_q <= left_entry;
				end
			end
		end else if (ctl.pop) begin
			entry_q <= right_entry;
		end
	end

endmodule

// File: hw/rtl/stable_priority_queue_core.sv
// Stable priority queue built as a row of shifting cells, one entry per cell.
// An item's result is registered and appears in the cycle after its transfer.
// Throughput: one push or pop per cycle unless stalled; every cell compares
// and shifts at once. Reset clears the entry count and the output valid;
// cell contents are left undefined and are never read until written.
module stable_priority_queue_core #(
	parameter int DEPTH  = spq_pkg::DEPTH_DEF,
	parameter int LEVELS = spq_pkg::LEVELS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      command,
	input  logic [spq_pkg::LVL_W-1:0] level,
	input  logic [spq_pkg::TAG_W-1:0] name_tag,
	input  logic [spq_pkg::TAG_W-1:0] id_tag,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      pop_valid,
	output logic [spq_pkg::LVL_W-1:0] out_level,
	output logic [spq_pkg::TAG_W-1:0] out_name_tag,
	output logic [spq_pkg::TAG_W-1:0] out_id_tag,
	output logic [1:0]                status,
	output logic [spq_pkg::OCC_W-1:0] occupancy
);

	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int LVL_TOP = LEVELS - 1;

	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          count_next;
	logic                      accept;
	logic                      is_pop;
	logic                      empty;
	logic                      full;
	logic [spq_pkg::LVL_W-1:0] lvl_sat;
	spq_pkg::cell_ctl_t        ctl;
	spq_pkg::entry_t           entry_w [DEPTH];
	logic                      ge_w    [DEPTH];
	spq_pkg::status_t          status_d;

	logic                      out_valid_q;
	logic                      pop_valid_q;
	spq_pkg::entry_t           out_entry_q;
	spq_pkg::status_t          status_q;
	logic [spq_pkg::OCC_W-1:0] occ_q;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign is_pop   = (spq_pkg::cmd_t'(command) == spq_pkg::CMD_POP);
	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_W'(DEPTH));

	always_comb begin
		if (32'(level) > 32'(LVL_TOP)) begin
			lvl_sat = spq_pkg::LVL_W'(LVL_TOP);
		end else begin
			lvl_sat = level;
		end
	end

	always_comb begin
		ctl.push        = accept && !is_pop && !full;
		ctl.pop         = accept && is_pop && !empty;
		ctl.entry.level = lvl_sat;
		ctl.entry.name  = name_tag;
		ctl.entry.ident = id_tag;
	end

	always_comb begin
		count_next = count_q;
		status_d   = spq_pkg::ST_OK;
		if (is_pop) begin
			if (empty) begin
				status_d = spq_pkg::ST_EMPTY;
			end else begin
				count_next = count_q - CNT_W'(1);
			end
		end else begin
			if (full) begin
				status_d = spq_pkg::ST_FULL;
			end else begin
				count_next = count_q + CNT_W'(1);
			end
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
		logic            left_ge;
		spq_pkg::entry_t left_entry;
		spq_pkg::entry_t right_entry;

		if (i == 0) begin : g_first
			assign left_ge    = 1'b1;
			assign left_entry = ctl.entry;
		end else begin : g_mid
			assign left_ge    = ge_w[i-1];
			assign left_entry = entry_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_entry = entry_w[i];
		end else begin : g_inner
			assign right_entry = entry_w[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occupied    (IDX < count_q),
			.left_ge     (left_ge),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.entry       (entry_w[i]),
			.ge          (ge_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pop_valid_q <= ctl.pop;
			status_q    <= status_d;
			occ_q       <= spq_pkg::OCC_W'(32'(count_next));
			if (ctl.pop) begin
				out_entry_q <= entry_w[0];
			end else begin
				out_entry_q <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign pop_valid    = pop_valid_q;
	assign out_level    = out_entry_q.level;
	assign out_name_tag = out_entry_q.name;
	assign out_id_tag   = out_entry_q.ident;
	assign status       = status_q;
	assign occupancy    = occ_q;

endmodule

// File: tb/tb_stable_priority_queue_core.sv
`timescale 1ns / 100ps

module tb_stable_priority_queue_core;

	localparam int DEPTH      = spq_pkg::DEPTH_DEF;
	localparam int LEVELS     = spq_pkg::LEVELS_DEF;
	localparam int IDLE_LIMIT = 1000;
	localparam int RANDOM_ITEMS = 630;

	typedef struct packed {
		spq_pkg::cmd_t             cmd;
		logic [spq_pkg::LVL_W-1:0] lvl;
		logic [spq_pkg::TAG_W-1:0] nm;
		logic [spq_pkg::TAG_W-1:0] id;
	} spq_item_t;

	typedef struct packed {
		logic                      pv;
		logic [spq_pkg::LVL_W-1:0] lvl;
		logic [spq_pkg::TAG_W-1:0] nm;
		logic [spq_pkg::TAG_W-1:0] id;
		logic [1:0]                st;
		logic [spq_pkg::OCC_W-1:0] occ;
	} spq_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic                      command;
	logic [spq_pkg::LVL_W-1:0] level;
	logic [spq_pkg::TAG_W-1:0] name_tag;
	logic [spq_pkg::TAG_W-1:0] id_tag;
	logic                      out_valid;
	logic                      out_stall;
	logic                      pop_valid;
	logic [spq_pkg::LVL_W-1:0] out_level;
	logic [spq_pkg::TAG_W-1:0] out_name_tag;
	logic [spq_pkg::TAG_W-1:0] out_id_tag;
	logic [1:0]                status;
	logic [spq_pkg::OCC_W-1:0] occupancy;

	spq_item_t   pending_items[$];
	spq_result_t expected_results[$];

	logic [spq_pkg::LVL_W-1:0] held_level[DEPTH];
	logic [spq_pkg::TAG_W-1:0] held_name[DEPTH];
	logic [spq_pkg::TAG_W-1:0] held_ident[DEPTH];
	int                        held_count;

	int items_total;
	int items_accepted;
	int fail_count;
	int idle_cycles;
	int burst_left;
	int gap_left;
	int stall_left;
	int stall_mode;
	int n_push;
	int n_pop;
	int n_full;
	int n_empty;
	int peak_occ;

	stable_priority_queue_core #(
		.DEPTH (DEPTH),
		.LEVELS(LEVELS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.level       (level),
		.name_tag    (name_tag),
		.id_tag      (id_tag),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pop_valid   (pop_valid),
		.out_level   (out_level),
		.out_name_tag(out_name_tag),
		.out_id_tag  (out_id_tag),
		.status      (status),
		.occupancy   (occupancy)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic spq_result_t queue_apply(spq_item_t it);
		spq_result_t r;
		logic [spq_pkg::LVL_W-1:0] lvl;
		int pos;
		int i;
		r = '0;
		if (it.cmd == spq_pkg::CMD_POP) begin
			if (held_count == 0) begin
				r.st = spq_pkg::ST_EMPTY;
			end else begin
				r.pv  = 1'b1;
				r.lvl = held_level[0];
				r.nm  = held_name[0];
				r.id  = held_ident[0];
				for (i = 0; i < held_count - 1; i++) begin
					held_level[i] = held_level[i + 1];
					held_name[i]  = held_name[i + 1];
					held_ident[i] = held_ident[i + 1];
				end
				held_count--;
				r.st = spq_pkg::ST_OK;
			end
		end else begin
			lvl = (it.lvl > LEVELS - 1) ? spq_pkg::LVL_W'(LEVELS - 1) : it.lvl;
			if (held_count >= DEPTH) begin
				r.st = spq_pkg::ST_FULL;
			end else begin
				pos = 0;
				while (pos < held_count && held_level[pos] >= lvl)
					pos++;
				for (i = held_count; i > pos; i--) begin
					held_level[i] = held_level[i - 1];
					held_name[i]  = held_name[i - 1];
					held_ident[i] = held_ident[i - 1];
				end
				held_level[pos] = lvl;
				held_name[pos]  = it.nm;
				held_ident[pos] = it.id;
				held_count++;
				r.st = spq_pkg::ST_OK;
			end
		end
		r.occ = spq_pkg::OCC_W'(held_count);
		return r;
	endfunction

	function automatic logic [spq_pkg::TAG_W-1:0] rand_tag();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_item(spq_pkg::cmd_t c, logic [spq_pkg::LVL_W-1:0] l,
			logic [spq_pkg::TAG_W-1:0] n, logic [spq_pkg::TAG_W-1:0] d);
		spq_item_t it;
		it.cmd = c;
		it.lvl = l;
		it.nm  = n;
		it.id  = d;
		pending_items.push_back(it);
	endtask

	// Driver: a new item is presented only once the previous one has made its transfer.
	always @(posedge clk) begin : driver_proc
		spq_item_t it;
		if (arst_n && (!in_valid || !in_stall)) begin
			if (gap_left > 0) begin
				gap_left = gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				it = pending_items.pop_front();
				in_valid <= 1'b1;
				command  <= it.cmd;
				level    <= it.lvl;
				name_tag <= it.nm;
				id_tag   <= it.id;
				burst_left = burst_left - 1;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : monitor_proc
		spq_item_t   acc;
		spq_result_t want;
		spq_result_t got;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				acc.cmd = spq_pkg::cmd_t'(command);
				acc.lvl = level;
				acc.nm  = name_tag;
				acc.id  = id_tag;
				want = queue_apply(acc);
				expected_results.push_back(want);
				items_accepted++;
				if (acc.cmd == spq_pkg::CMD_POP)
					n_pop++;
				else
					n_push++;
				if (want.st == spq_pkg::ST_FULL)
					n_full++;
				if (want.st == spq_pkg::ST_EMPTY)
					n_empty++;
				if (held_count > peak_occ)
					peak_occ = held_count;
			end
			if (out_valid && !out_stall) begin
				got.pv  = pop_valid;
				got.lvl = out_level;
				got.nm  = out_name_tag;
				got.id  = out_id_tag;
				got.st  = status;
				got.occ = occupancy;
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: pv=%b lvl=%0d nm=%h id=%h st=%0d occ=%0d",
							got.pv, got.lvl, got.nm, got.id, got.st, got.occ);
				end else begin
					want = expected_results.pop_front();
					if (got.pv !== want.pv || got.lvl !== want.lvl || got.nm !== want.nm
							|| got.id !== want.id || got.st !== want.st
							|| got.occ !== want.occ) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("mismatch: expected pv=%b lvl=%0d nm=%h id=%h st=%0d occ=%0d",
								want.pv, want.lvl, want.nm, want.id, want.st, want.occ);
							$display("          got      pv=%b lvl=%0d nm=%h id=%h st=%0d occ=%0d",
								got.pv, got.lvl, got.nm, got.id, got.st, got.occ);
						end
					end
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles = idle_cycles + 1;
			if (stall_left <= 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_left = $urandom_range(20, 120);
			end
			stall_left = stall_left - 1;
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 9) < 7);
			endcase
		end
	end

	initial begin : watchdog_proc
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus_proc
		int made;
		int seg_len;
		int push_pct;
		int k;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		command   = spq_pkg::CMD_PUSH;
		level     = '0;
		name_tag  = '0;
		id_tag    = '0;
		out_stall = 1'b0;
		held_count = 0;
		items_accepted = 0;
		fail_count = 0;
		idle_cycles = 0;
		burst_left = 0;
		gap_left = 0;
		stall_left = 0;
		stall_mode = 0;
		n_push = 0;
		n_pop = 0;
		n_full = 0;
		n_empty = 0;
		peak_occ = 0;

		add_item(spq_pkg::CMD_POP,  2'd3, '1, '1);
		add_item(spq_pkg::CMD_PUSH, 2'd0, '0, '0);
		add_item(spq_pkg::CMD_PUSH, 2'd0, '1, '1);
		add_item(spq_pkg::CMD_PUSH, 2'd2, 32'h5555_5555, 32'hAAAA_AAAA);
		add_item(spq_pkg::CMD_PUSH, 2'd1, 32'hAAAA_AAAA, 32'h5555_5555);
		add_item(spq_pkg::CMD_PUSH, 2'd3, 32'h0000_0001, 32'h8000_0000);
		add_item(spq_pkg::CMD_PUSH, 2'd2, 32'h8000_0000, 32'h0000_0001);
		add_item(spq_pkg::CMD_PUSH, 2'd1, 32'h1234_5678, 32'h9ABC_DEF0);
		for (k = 0; k < 8; k++)
			add_item(spq_pkg::CMD_POP, spq_pkg::LVL_W'(k), rand_tag(), rand_tag());

		// Fill, drain and mixed stretches so that both the full and the empty queue recur.
		made = 0;
		while (made < RANDOM_ITEMS) begin
			seg_len = $urandom_range(10, 40);
			case ($urandom_range(0, 2))
				0: push_pct = 85;
				1: push_pct = 15;
				default: push_pct = 50;
			endcase
			for (k = 0; k < seg_len; k++) begin
				if ($urandom_range(0, 99) < push_pct)
					add_item(spq_pkg::CMD_PUSH, spq_pkg::LVL_W'($urandom_range(0, 3)),
						rand_tag(), rand_tag());
				else
					add_item(spq_pkg::CMD_POP, spq_pkg::LVL_W'($urandom_range(0, 3)),
						rand_tag(), rand_tag());
			end
			made += seg_len;
		end
		items_total = pending_items.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (items_accepted < items_total || expected_results.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (expected_results.size() != 0)
			fail_count++;

		$display("covered %0d transfers: %0d pushes, %0d pops, peak occupancy %0d",
			items_accepted, n_push, n_pop, peak_occ);
		$display("dropped pushes on a full queue %0d, pops on an empty queue %0d, failures %0d",
			n_full, n_empty, fail_count);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/stable_priority_queue_core.sv
tb/tb_stable_priority_queue_core.sv
